### hw/rtl/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
package mtep_pkg;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_DELTA  = 5'b00001,
        PH_STATUS = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_MTYPE  = 5'b01000,
        PH_LEN    = 5'b10000
    } phase_t;

    // Top level sequencer, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } seq_t;

    localparam logic [1:0] ROLE_DELTA = 2'd0;
    localparam logic [1:0] ROLE_FWD   = 2'd1;
    localparam logic [1:0] ROLE_META  = 2'd2;
    localparam logic [1:0] ROLE_DROP  = 2'd3;

    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE   = 8'hF7;
    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
    localparam logic [7:0] STATUS_PRESSURE = 8'hD0;
    localparam logic [7:0] HI_NIBBLE_MASK  = 8'hF0;
    localparam logic [7:0] META_SET_TEMPO  = 8'h51;

    localparam int          TPQ_W      = 15;
    localparam logic [14:0] TPQ_RESET  = 15'd120;
    localparam int          TEMPO_W    = 24;
    localparam int          DIV_STEPS  = 24;
    localparam int          DIV_CNT_W  = 5;
    localparam logic [4:0]  DIV_LAST   = 5'd23;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_role;
        logic        event_start;
        logic        event_end;
        logic [31:0] event_tick;
        logic        tempo_valid;
        logic [23:0] tempo_us;
        logic [23:0] tick_divisor;
    } res_t;

endpackage

### hw/rtl/mtep_in_if.sv
// Input channel carrying one track byte per beat.
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       new_track;

    modport source (output valid, output track_byte, output new_track, input ready);
    modport sink (input valid, input track_byte, input new_track, output ready);
endinterface

### hw/rtl/mtep_out_if.sv
// Output channel carrying one decoded byte result per beat.
interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_role;
    logic        event_start;
    logic        event_end;
    logic [31:0] event_tick;
    logic        tempo_valid;
    logic [23:0] tempo_us;
    logic [23:0] tick_divisor;

    modport source (output valid, output out_byte, output byte_role, output event_start,
                    output event_end, output event_tick, output tempo_valid,
                    output tempo_us, output tick_divisor, input ready);
    modport sink (input valid, input out_byte, input byte_role, input event_start,
                  input event_end, input event_tick, input tempo_valid,
                  input tempo_us, input tick_divisor, output ready);
endinterface

### hw/rtl/mtep_cfg_if.sv
// Configuration write channel for the ticks-per-quarter register.
interface mtep_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] ticks_per_quarter;

    modport source (output valid, output ticks_per_quarter, input ready);
    modport sink (input valid, input ticks_per_quarter, output ready);
endinterface

### hw/rtl/midi_track_event_parser.sv
// Block usage:
// The track channel takes one byte of a MIDI track chunk body per beat; new_track set
// on a beat clears the parser and the tick time before that byte is parsed.
// The result channel gives one beat per track byte: the byte echoed, its role, event
// start and end marks, the absolute tick, and on a completed set-tempo event the
// tempo and its quotient by ticks per quarter.
// The cfg channel writes ticks_per_quarter; it is always ready and should be written
// only while the block is idle.
// Flow: an ordinary byte appears on the result channel in the cycle after it is taken,
// and a new byte is taken every cycle while the result channel keeps up. The byte that
// completes a set-tempo event runs the serial divider, one quotient bit per cycle, and
// its result passes the divide and finish states; the track channel is not ready meanwhile.
// The output register frees up in the same cycle its beat is taken, so the next byte
// can be taken then. When the receiver stalls, the result is held and the track
// channel stops taking bytes.
// Reset clears the parser to the delta phase with tick zero, empties the output
// register and sets ticks_per_quarter to 120.
module midi_track_event_parser
(
    input  logic           clk,
    input  logic           rst_n,
    mtep_in_if.sink        track,
    mtep_out_if.source     result,
    mtep_cfg_if.sink       cfg
);

    mtep_pkg::seq_t  state_reg, state_next;
    mtep_pkg::res_t  pres;
    mtep_pkg::res_t  hold_reg, hold_next;
    mtep_pkg::res_t  out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic [14:0]     tpq_reg;
    logic            accept;
    logic            out_free;
    logic            div_start;
    logic            div_done;
    logic [23:0]     div_quo;

    assign out_free    = !out_valid_reg || result.ready;
    assign track.ready = (state_reg == mtep_pkg::ST_IDLE) && out_free;
    assign accept      = track.valid && track.ready;
    assign cfg.ready   = 1'b1;

    mtep_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .track_byte (track.track_byte),
        .new_track  (track.new_track),
        .res        (pres)
    );

    mtep_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pres.tempo_us),
        .divisor  (tpq_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mtep_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (pres.tempo_valid)
                    begin
                        hold_next  = pres;
                        div_start  = 1'b1;
                        state_next = mtep_pkg::ST_DIV;
                    end
                    else
                    begin
                        out_next       = pres;
                        out_valid_next = 1'b1;
                    end
                end
            end
            mtep_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    hold_next.tick_divisor = div_quo;
                    state_next             = mtep_pkg::ST_FIN;
                end
            end
            mtep_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = mtep_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtep_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtep_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            tpq_reg       <= mtep_pkg::TPQ_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                tpq_reg <= cfg.ticks_per_quarter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_reg.out_byte;
    assign result.byte_role    = out_reg.byte_role;
    assign result.event_start  = out_reg.event_start;
    assign result.event_end    = out_reg.event_end;
    assign result.event_tick   = out_reg.event_tick;
    assign result.tempo_valid  = out_reg.tempo_valid;
    assign result.tempo_us     = out_reg.tempo_us;
    assign result.tick_divisor = out_reg.tick_divisor;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mtep_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_tempo_goes_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pres.tempo_valid) |=> (state_reg == mtep_pkg::ST_DIV))
        else $error("tempo completion did not start the divider");

    a_tempo_is_meta_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.tempo_valid) |->
        (result.byte_role == mtep_pkg::ROLE_META && result.event_end))
        else $error("tempo result on a byte that does not end a meta event");

    a_drop_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.byte_role == mtep_pkg::ROLE_DROP) |->
        (!result.event_start && !result.event_end))
        else $error("dropped byte carries an event mark");

endmodule

### hw/rtl/mtep_parser.sv
// Byte-level track parser: phase state, delta and length decoding, tempo capture.
module mtep_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       track_byte,
    input  logic             new_track,
    output mtep_pkg::res_t   res
);

    mtep_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [31:0] delta_reg, delta_next, cur_delta;
    logic [31:0] tick_reg, tick_next, cur_tick;
    logic [1:0]  run_len_reg, run_len_next, cur_run_len;
    logic [31:0] left_reg, left_next, cur_left;
    logic        meta_reg, meta_next, cur_meta;
    logic        tempo_reg, tempo_next, cur_tempo;
    logic [23:0] tacc_reg, tacc_next, cur_tacc;

    logic [31:0] delta_shift;
    logic [31:0] left_shift;
    logic [31:0] left_dec;
    logic [23:0] tacc_shift;
    logic [7:0]  hi;
    logic [1:0]  role;
    logic        ev_start;
    logic        ev_end;
    logic        tvalid;
    logic [23:0] tus;

    always_comb
    begin
        // A new track clears all parser state before the byte is taken.
        cur_phase   = new_track ? mtep_pkg::PH_DELTA : phase_reg;
        cur_delta   = new_track ? 32'd0 : delta_reg;
        cur_tick    = new_track ? 32'd0 : tick_reg;
        cur_run_len = new_track ? 2'd0 : run_len_reg;
        cur_left    = new_track ? 32'd0 : left_reg;
        cur_meta    = new_track ? 1'b0 : meta_reg;
        cur_tempo   = new_track ? 1'b0 : tempo_reg;
        cur_tacc    = new_track ? 24'd0 : tacc_reg;

        delta_shift = {cur_delta[24:0], 7'd0} + {25'd0, track_byte[6:0]};
        left_shift  = {cur_left[24:0], 7'd0} + {25'd0, track_byte[6:0]};
        left_dec    = cur_left - 32'd1;
        tacc_shift  = {cur_tacc[15:0], track_byte};
        hi          = track_byte & mtep_pkg::HI_NIBBLE_MASK;

        phase_next   = cur_phase;
        delta_next   = cur_delta;
        tick_next    = cur_tick;
        run_len_next = cur_run_len;
        left_next    = cur_left;
        meta_next    = cur_meta;
        tempo_next   = cur_tempo;
        tacc_next    = cur_tacc;

        role     = mtep_pkg::ROLE_DELTA;
        ev_start = 1'b0;
        ev_end   = 1'b0;
        tvalid   = 1'b0;
        tus      = 24'd0;

        case (cur_phase)
            mtep_pkg::PH_STATUS:
            begin
                ev_start = 1'b1;
                if (!track_byte[7])
                begin
                    if (cur_run_len == 2'd0)
                    begin
                        // Data byte with no running status is dropped.
                        role       = mtep_pkg::ROLE_DROP;
                        ev_start   = 1'b0;
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        role       = mtep_pkg::ROLE_FWD;
                        meta_next  = 1'b0;
                        tempo_next = 1'b0;
                        left_next  = {30'd0, cur_run_len} - 32'd1;
                        if (cur_run_len == 2'd1)
                        begin
                            ev_end     = 1'b1;
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            phase_next = mtep_pkg::PH_DATA;
                        end
                    end
                end
                else if (hi != mtep_pkg::HI_NIBBLE_MASK)
                begin
                    role       = mtep_pkg::ROLE_FWD;
                    meta_next  = 1'b0;
                    tempo_next = 1'b0;
                    run_len_next = (hi == mtep_pkg::STATUS_PROGRAM ||
                                    hi == mtep_pkg::STATUS_PRESSURE) ? 2'd1 : 2'd2;
                    left_next  = {30'd0, run_len_next};
                    phase_next = mtep_pkg::PH_DATA;
                end
                else if (track_byte == mtep_pkg::STATUS_SYSEX ||
                         track_byte == mtep_pkg::STATUS_ESCAPE)
                begin
                    role       = mtep_pkg::ROLE_FWD;
                    meta_next  = 1'b0;
                    tempo_next = 1'b0;
                    left_next  = 32'd0;
                    phase_next = mtep_pkg::PH_LEN;
                end
                else if (track_byte == mtep_pkg::STATUS_META)
                begin
                    role       = mtep_pkg::ROLE_META;
                    meta_next  = 1'b1;
                    tempo_next = 1'b0;
                    left_next  = 32'd0;
                    phase_next = mtep_pkg::PH_MTYPE;
                end
                else
                begin
                    // Unknown system status: drop, keep running status.
                    role       = mtep_pkg::ROLE_DROP;
                    ev_start   = 1'b0;
                    phase_next = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_MTYPE:
            begin
                role       = mtep_pkg::ROLE_META;
                tempo_next = (track_byte == mtep_pkg::META_SET_TEMPO);
                left_next  = 32'd0;
                phase_next = mtep_pkg::PH_LEN;
            end
            mtep_pkg::PH_LEN:
            begin
                role      = cur_meta ? mtep_pkg::ROLE_META : mtep_pkg::ROLE_FWD;
                left_next = left_shift;
                if (!track_byte[7])
                begin
                    tempo_next = cur_meta && cur_tempo && (left_shift == 32'd3);
                    tacc_next  = 24'd0;
                    if (left_shift == 32'd0)
                    begin
                        ev_end     = 1'b1;
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_DATA;
                    end
                end
            end
            mtep_pkg::PH_DATA:
            begin
                role      = cur_meta ? mtep_pkg::ROLE_META : mtep_pkg::ROLE_FWD;
                tacc_next = tacc_shift;
                left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    ev_end     = 1'b1;
                    phase_next = mtep_pkg::PH_DELTA;
                    if (cur_tempo)
                    begin
                        tvalid     = 1'b1;
                        tus        = tacc_shift;
                        tempo_next = 1'b0;
                    end
                end
            end
            default:
            begin
                role = mtep_pkg::ROLE_DELTA;
                if (!track_byte[7])
                begin
                    tick_next  = cur_tick + delta_shift;
                    delta_next = 32'd0;
                    phase_next = mtep_pkg::PH_STATUS;
                end
                else
                begin
                    delta_next = delta_shift;
                    phase_next = mtep_pkg::PH_DELTA;
                end
            end
        endcase

        res.out_byte     = track_byte;
        res.byte_role    = role;
        res.event_start  = ev_start;
        res.event_end    = ev_end;
        res.event_tick   = tick_next;
        res.tempo_valid  = tvalid;
        res.tempo_us     = tus;
        res.tick_divisor = 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mtep_pkg::PH_DELTA;
            delta_reg   <= 32'd0;
            tick_reg    <= 32'd0;
            run_len_reg <= 2'd0;
            left_reg    <= 32'd0;
            meta_reg    <= 1'b0;
            tempo_reg   <= 1'b0;
            tacc_reg    <= 24'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            delta_reg   <= delta_next;
            tick_reg    <= tick_next;
            run_len_reg <= run_len_next;
            left_reg    <= left_next;
            meta_reg    <= meta_next;
            tempo_reg   <= tempo_next;
            tacc_reg    <= tacc_next;
        end
    end

endmodule

### hw/rtl/mtep_divider.sv
// Serial restoring divider: one quotient bit per cycle, tempo over ticks per quarter.
module mtep_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [14:0] divisor,
    output logic        done,
    output logic [23:0] quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mtep_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [14:0]                   rem_reg, rem_next;
    logic [23:0]                   quo_reg, quo_next;
    logic [14:0]                   dvs_reg, dvs_next;
    logic [15:0]                   trial;
    logic [15:0]                   diff;
    logic                          ge;

    // A zero divisor always subtracts, which yields an all-ones quotient.
    always_comb
    begin
        trial = {rem_reg, quo_reg[23]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = 15'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[14:0] : trial[14:0];
            quo_next = {quo_reg[22:0], ge};
            cnt_next = cnt_reg + mtep_pkg::DIV_CNT_W'(1);
            if (cnt_reg == mtep_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the MIDI track event parser: directed and random track streams.
`timescale 1ns / 1ps

module tb_top;

    localparam int          ITEM_TARGET   = 1650;
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          LONG_HOLD     = 400;
    localparam int          HOLD_AFTER    = 500;
    localparam logic [7:0]  NOTE_ON           = 8'h90;
    localparam logic [7:0]  SYS_UNDEFINED     = 8'hF4;
    localparam logic [7:0]  META_END_OF_TRACK = 8'h2F;

    // Predicts the decoded beat for every accepted track byte and checks
    // the result beats against those predictions in order.
    class track_decode_board;
        logic [14:0]       tpq;
        mtep_pkg::phase_t  phase;
        logic [31:0]       delta_sum;
        logic [31:0]       abs_tick;
        logic [31:0]       remaining;
        logic [1:0]        run_len;
        logic              in_meta;
        logic              tempo_pending;
        logic [23:0]       tempo_shift;
        mtep_pkg::res_t    pending_decodes[$];
        int                mismatches;

        function new();
            tpq = mtep_pkg::TPQ_RESET;
            mismatches = 0;
            clear_track();
        endfunction

        function void clear_track();
            phase = mtep_pkg::PH_DELTA;
            delta_sum = '0;
            abs_tick = '0;
            remaining = '0;
            run_len = '0;
            in_meta = 1'b0;
            tempo_pending = 1'b0;
            tempo_shift = '0;
        endfunction

        function void predict_byte(logic [7:0] b, logic nt);
            mtep_pkg::res_t r;
            logic [7:0]     hi;
            r = '0;
            r.out_byte = b;
            hi = b & mtep_pkg::HI_NIBBLE_MASK;
            if (nt)
            begin
                clear_track();
            end
            case (phase)
                mtep_pkg::PH_STATUS:
                begin
                    r.event_start = 1'b1;
                    if (b < 8'h80)
                    begin
                        if (run_len == 2'd0)
                        begin
                            r.byte_role = mtep_pkg::ROLE_DROP;
                            r.event_start = 1'b0;
                            phase = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            // Running status: this byte is already the first data byte.
                            r.byte_role = mtep_pkg::ROLE_FWD;
                            in_meta = 1'b0;
                            tempo_pending = 1'b0;
                            remaining = {30'd0, run_len} - 32'd1;
                            if (remaining == 32'd0)
                            begin
                                r.event_end = 1'b1;
                                phase = mtep_pkg::PH_DELTA;
                            end
                            else
                            begin
                                phase = mtep_pkg::PH_DATA;
                            end
                        end
                    end
                    else if (b < mtep_pkg::STATUS_SYSEX)
                    begin
                        r.byte_role = mtep_pkg::ROLE_FWD;
                        in_meta = 1'b0;
                        tempo_pending = 1'b0;
                        run_len = (hi == mtep_pkg::STATUS_PROGRAM ||
                                   hi == mtep_pkg::STATUS_PRESSURE) ? 2'd1 : 2'd2;
                        remaining = {30'd0, run_len};
                        phase = mtep_pkg::PH_DATA;
                    end
                    else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE)
                    begin
                        r.byte_role = mtep_pkg::ROLE_FWD;
                        in_meta = 1'b0;
                        tempo_pending = 1'b0;
                        remaining = '0;
                        phase = mtep_pkg::PH_LEN;
                    end
                    else if (b == mtep_pkg::STATUS_META)
                    begin
                        r.byte_role = mtep_pkg::ROLE_META;
                        in_meta = 1'b1;
                        tempo_pending = 1'b0;
                        remaining = '0;
                        phase = mtep_pkg::PH_MTYPE;
                    end
                    else
                    begin
                        // Unknown system status keeps the running status.
                        r.byte_role = mtep_pkg::ROLE_DROP;
                        r.event_start = 1'b0;
                        phase = mtep_pkg::PH_DELTA;
                    end
                end
                mtep_pkg::PH_MTYPE:
                begin
                    r.byte_role = mtep_pkg::ROLE_META;
                    tempo_pending = (b == mtep_pkg::META_SET_TEMPO);
                    remaining = '0;
                    phase = mtep_pkg::PH_LEN;
                end
                mtep_pkg::PH_LEN:
                begin
                    r.byte_role = in_meta ? mtep_pkg::ROLE_META : mtep_pkg::ROLE_FWD;
                    remaining = (remaining << 7) + {25'd0, b[6:0]};
                    if (!b[7])
                    begin
                        tempo_pending = in_meta && tempo_pending && (remaining == 32'd3);
                        tempo_shift = '0;
                        if (remaining == 32'd0)
                        begin
                            r.event_end = 1'b1;
                            phase = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            phase = mtep_pkg::PH_DATA;
                        end
                    end
                end
                mtep_pkg::PH_DATA:
                begin
                    r.byte_role = in_meta ? mtep_pkg::ROLE_META : mtep_pkg::ROLE_FWD;
                    tempo_shift = {tempo_shift[15:0], b};
                    remaining = remaining - 32'd1;
                    if (remaining == 32'd0)
                    begin
                        r.event_end = 1'b1;
                        phase = mtep_pkg::PH_DELTA;
                        if (tempo_pending)
                        begin
                            r.tempo_valid = 1'b1;
                            r.tempo_us = tempo_shift;
                            r.tick_divisor = (tpq == '0) ? 24'hFF_FFFF
                                                         : tempo_shift / {9'd0, tpq};
                            tempo_pending = 1'b0;
                        end
                    end
                end
                default:
                begin
                    r.byte_role = mtep_pkg::ROLE_DELTA;
                    delta_sum = (delta_sum << 7) + {25'd0, b[6:0]};
                    if (!b[7])
                    begin
                        abs_tick = abs_tick + delta_sum;
                        delta_sum = '0;
                        phase = mtep_pkg::PH_STATUS;
                    end
                    else
                    begin
                        phase = mtep_pkg::PH_DELTA;
                    end
                end
            endcase
            r.event_tick = abs_tick;
            pending_decodes.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                if (mismatches < 60)
                begin
                    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                             $time, field, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_decoded(mtep_pkg::res_t got);
            mtep_pkg::res_t want;
            if (pending_decodes.size() == 0)
            begin
                if (mismatches < 60)
                begin
                    $display("%0t: result beat with nothing expected: expected none, actual 0x%0h",
                             $time, got.out_byte);
                end
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
            compare_field("event_start", 32'(want.event_start), 32'(got.event_start));
            compare_field("event_end", 32'(want.event_end), 32'(got.event_end));
            compare_field("event_tick", want.event_tick, got.event_tick);
            compare_field("tempo_valid", 32'(want.tempo_valid), 32'(got.tempo_valid));
            compare_field("tempo_us", 32'(want.tempo_us), 32'(got.tempo_us));
            compare_field("tick_divisor", 32'(want.tick_divisor), 32'(got.tick_divisor));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mtep_in_if  track_if ();
    mtep_out_if result_if ();
    mtep_cfg_if cfg_if ();

    midi_track_event_parser dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .track  (track_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    track_decode_board board;
    int burst_left;
    int sent_count;
    int gen_run_len;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Offers one track byte and waits for its beat, idling between bursts.
    task automatic send_byte(input logic [7:0] b, input logic nt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
            track_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        track_if.track_byte <= b;
        track_if.new_track <= nt;
        track_if.valid <= 1'b1;
        do @(posedge clk); while (!track_if.ready);
        board.predict_byte(b, nt);
        sent_count++;
    endtask

    task automatic send_delta(input logic nt);
        int   sel;
        int   nbytes;
        logic first_nt;
        sel = $urandom_range(0, 99);
        nbytes = (sel < 60) ? 1 : (sel < 85) ? 2 : (sel < 95) ? 3 : (sel < 98) ? 4 : 5;
        first_nt = nt;
        repeat (nbytes - 1)
        begin
            send_byte({1'b1, 7'($urandom)}, first_nt);
            first_nt = 1'b0;
        end
        send_byte({1'b0, 7'($urandom)}, first_nt);
    endtask

    // Length quantity, now and then with a redundant leading continuation byte.
    task automatic send_length(input int n);
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte({1'b1, 7'd0}, 1'b0);
        end
        if (n >= 128)
        begin
            send_byte({1'b1, 7'(n >> 7)}, 1'b0);
        end
        send_byte({1'b0, 7'(n)}, 1'b0);
    endtask

    task automatic send_body(input int n);
        repeat (n)
        begin
            send_byte(8'($urandom), 1'b0);
        end
    endtask

    // One mostly well-formed track event with random content; a few are noise.
    task automatic gen_event();
        int         evt_kind;
        int         n;
        logic       nt;
        logic [7:0] status;
        evt_kind = $urandom_range(0, 99);
        nt = ($urandom_range(0, 49) == 0);
        if (nt)
        begin
            gen_run_len = 0;
        end
        send_delta(nt);
        if (evt_kind < 30 || (evt_kind < 45 && gen_run_len == 0))
        begin
            status = 8'($urandom_range(8'h80, 8'hEF));
            gen_run_len = ((status & mtep_pkg::HI_NIBBLE_MASK) == mtep_pkg::STATUS_PROGRAM ||
                           (status & mtep_pkg::HI_NIBBLE_MASK) == mtep_pkg::STATUS_PRESSURE)
                          ? 1 : 2;
            send_byte(status, 1'b0);
            repeat (gen_run_len) send_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
        end
        else if (evt_kind < 45)
        begin
            repeat (gen_run_len) send_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
        end
        else if (evt_kind < 60)
        begin
            send_byte($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX : mtep_pkg::STATUS_ESCAPE,
                      1'b0);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 10);
            send_length(n);
            send_body(n);
        end
        else if (evt_kind < 75)
        begin
            send_byte(mtep_pkg::STATUS_META, 1'b0);
            send_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
            n = $urandom_range(0, 12);
            send_length(n);
            send_body(n);
        end
        else if (evt_kind < 88)
        begin
            send_byte(mtep_pkg::STATUS_META, 1'b0);
            send_byte(mtep_pkg::META_SET_TEMPO, 1'b0);
            send_length(3);
            send_body(3);
        end
        else if (evt_kind < 92)
        begin
            // Set-tempo type with a length other than three.
            send_byte(mtep_pkg::STATUS_META, 1'b0);
            send_byte(mtep_pkg::META_SET_TEMPO, 1'b0);
            n = $urandom_range(0, 4);
            if (n >= 3)
            begin
                n++;
            end
            send_length(n);
            send_body(n);
        end
        else if (evt_kind < 96)
        begin
            status = 8'($urandom_range(8'hF1, 8'hFD));
            if (status >= mtep_pkg::STATUS_ESCAPE)
            begin
                status++;
            end
            send_byte(status, 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_random(input int goal);
        while (sent_count < goal)
        begin
            gen_event();
        end
    endtask

    // Lets every expected beat come back, then leaves the block idle a while.
    task automatic settle();
        track_if.valid <= 1'b0;
        burst_left = 0;
        while (board.pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tpq(input logic [14:0] v);
        cfg_if.ticks_per_quarter <= v;
        cfg_if.valid <= 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board.tpq = v;
    endtask

    // Result side: checks each beat, then decides ready for the next cycle.
    initial
    begin
        int             seen;
        int             mode;
        int             mode_left;
        int             hold_left;
        logic           hold_done;
        mtep_pkg::res_t got;
        seen = 0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got.out_byte = result_if.out_byte;
                got.byte_role = result_if.byte_role;
                got.event_start = result_if.event_start;
                got.event_end = result_if.event_end;
                got.event_tick = result_if.event_tick;
                got.tempo_valid = result_if.tempo_valid;
                got.tempo_us = result_if.tempo_us;
                got.tick_divisor = result_if.tick_divisor;
                board.check_decoded(got);
                seen++;
            end
            if (!hold_done && seen == HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (mode == 0)
            begin
                result_if.ready <= 1'b1;
            end
            else if (mode == 1)
            begin
                result_if.ready <= ($urandom_range(0, 2) != 0);
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 4) == 0);
            end
        end
    end

    // Ends the run when no beat of any channel has moved for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((track_if.valid && track_if.ready) || (result_if.valid && result_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [8:0]  directed_seq[$];
        logic [14:0] tpq_plan[$];
        int          per_phase;
        int          goal;
        board = new();
        burst_left = 0;
        sent_count = 0;
        gen_run_len = 0;
        rst_n = 1'b0;
        track_if.valid = 1'b0;
        track_if.track_byte = '0;
        track_if.new_track = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.ticks_per_quarter = mtep_pkg::TPQ_RESET;

        directed_seq = '{
            {1'b1, 8'h00}, {1'b0, NOTE_ON}, {1'b0, 8'h3C}, {1'b0, 8'h7F},
            {1'b0, 8'h00}, {1'b0, 8'h40}, {1'b0, 8'h00},
            {1'b0, 8'h81}, {1'b0, 8'h00}, {1'b0, mtep_pkg::STATUS_META},
            {1'b0, mtep_pkg::META_SET_TEMPO},
            {1'b0, 8'h03}, {1'b0, 8'h07}, {1'b0, 8'hA1}, {1'b0, 8'h20},
            {1'b0, 8'h00}, {1'b0, mtep_pkg::STATUS_ESCAPE}, {1'b0, 8'h00},
            {1'b0, 8'h00}, {1'b0, SYS_UNDEFINED},
            {1'b0, 8'h00}, {1'b0, mtep_pkg::STATUS_META}, {1'b0, META_END_OF_TRACK},
            {1'b0, 8'h00},
            {1'b1, 8'h00}, {1'b0, 8'h45}
        };
        tpq_plan = '{15'd1, 15'h7FFF, 15'd0, 15'($urandom_range(2, 32766)), 15'd96,
                     15'($urandom_range(1, 500))};
        per_phase = (ITEM_TARGET - directed_seq.size()) / (tpq_plan.size() + 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The first phase runs with the reset value of ticks per quarter.
        foreach (directed_seq[i])
        begin
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end
        goal = sent_count + per_phase;
        run_random(goal);
        foreach (tpq_plan[i])
        begin
            settle();
            write_tpq(tpq_plan[i]);
            goal = sent_count + per_phase;
            run_random(goal);
        end
        settle();

        if (board.mismatches == 0 && board.pending_decodes.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_in_if.sv
hw/rtl/mtep_out_if.sv
hw/rtl/mtep_cfg_if.sv
hw/rtl/mtep_parser.sv
hw/rtl/mtep_divider.sv
hw/rtl/midi_track_event_parser.sv
verif/tb_top.sv
